// ===== hw/rtl/imhq_pkg.sv =====
// ----------------------------------------------------------------------------
// imhq_pkg
// Types and constants shared by the indexed min-heap queue.
// ----------------------------------------------------------------------------
package imhq_pkg;

	localparam int unsigned CAPACITY_DEF = 64;
	localparam int unsigned KEY_BITS_DEF = 32;

	typedef enum logic [1:0] {
		CMD_INSERT  = 2'd0,
		CMD_EXTRACT = 2'd1,
		CMD_CHANGE  = 2'd2,
		CMD_SEARCH  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_RANGE     = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] item_key;
		logic [31:0]        item_value;
		logic [5:0]         position;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] taken_key;
		logic [31:0]        taken_value;
		logic [5:0]         found_position;
		logic signed [31:0] top_key;
		logic [31:0]        top_value;
		logic [6:0]         entry_count;
	} out_item_t;

endpackage

// ===== hw/rtl/imhq_ram.sv =====
// ----------------------------------------------------------------------------
// imhq_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module imhq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== hw/rtl/indexed_min_heap_queue_core.sv =====
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_core
// Binary min-heap of key/value entries held in one synchronous RAM.
// ----------------------------------------------------------------------------
// One item is one command, and the block works on one item at a time. All
// heap traffic goes through a single-port RAM whose entries hold a key and a
// value. Insert writes the new entry and sifts it up; extract reads the root
// and the last entry, moves the last entry to the root and sifts it down;
// change-key rewrites the key and sifts up or down; search scans the entries
// in order for the value and ends with a read of the root. A finished result
// sits in an output register, and the next item is taken once that register
// is free.
module indexed_min_heap_queue_core #(
	parameter int unsigned CAPACITY = imhq_pkg::CAPACITY_DEF,
	parameter int unsigned KEY_BITS = imhq_pkg::KEY_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  imhq_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output imhq_pkg::out_item_t out_item
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned EW = KEY_BITS + 32;

	typedef enum logic [4:0] {
		S_IDLE,
		S_INS_WR,
		S_UP_RDP,
		S_UP_WAITP,
		S_UP_RDC,
		S_UP_WAITC,
		S_UP_SWAP1,
		S_EX_RDROOT,
		S_EX_WAITROOT,
		S_EX_RDLAST,
		S_EX_WAITLAST,
		S_EX_WRROOT,
		S_CK_RD,
		S_CK_WAIT,
		S_CK_WR,
		S_DN_RDL,
		S_DN_WAITL,
		S_DN_RDR,
		S_DN_WAITR,
		S_DN_SWAP1,
		S_SR_RD,
		S_SR_WAIT,
		S_TOP_RD,
		S_TOP_WAIT,
		S_DONE
	} state_t;

	state_t            state_q;
	logic              ram_we;
	logic [AW-1:0]     ram_addr;
	logic [EW-1:0]     ram_wdata;
	logic [EW-1:0]     ram_rdata;

	logic [CW-1:0]     count_q;
	logic [1:0]        cmd_q;
	logic [1:0]        op_q;       // command as accepted
	logic [EW-1:0]     cur_q;      // entry being sifted
	logic [AW-1:0]     pos_q;      // its current position
	logic [AW-1:0]     other_q;    // parent or chosen child position
	logic [EW-1:0]     other_ent_q;
	logic [EW-1:0]     lch_q;
	logic [31:0]       sval_q;
	logic [CW-1:0]     scan_q;
	logic [2:0]        status_q;
	logic [EW-1:0]     taken_q;
	logic [AW-1:0]     fpos_q;
	logic              out_valid_q;
	imhq_pkg::out_item_t out_q;

	logic [KEY_BITS-1:0] new_key;
	logic [CW:0]         lidx, ridx;

	assign new_key = KEY_BITS'($signed(in_item.item_key));
	assign lidx = {pos_q, 1'b1} + (CW+1)'(0);
	assign ridx = (CW+1)'({pos_q, 1'b0}) + (CW+1)'(2);

	function automatic logic key_lt(input logic [EW-1:0] a, input logic [EW-1:0] b);
		return $signed(a[EW-1:32]) < $signed(b[EW-1:32]);
	endfunction

	function automatic logic [31:0] key_field(input logic [EW-1:0] e);
		return 32'($signed(e[EW-1:32]));
	endfunction

	imhq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = pos_q;
		ram_wdata = cur_q;
		case (state_q)
			S_INS_WR, S_EX_WRROOT, S_CK_WR: begin
				ram_we = 1'b1;
			end
			S_UP_RDP, S_UP_WAITP, S_UP_RDC, S_UP_WAITC: begin
				ram_addr = other_q;
			end
			S_UP_SWAP1: begin
				// Move the other entry into the current slot.
				ram_we    = 1'b1;
				ram_wdata = other_ent_q;
			end
			S_EX_RDLAST, S_EX_WAITLAST: begin
				ram_addr = AW'(count_q);
			end
			S_DN_RDL, S_DN_WAITL: begin
				ram_addr = AW'(lidx);
			end
			S_DN_RDR, S_DN_WAITR: begin
				ram_addr = AW'(ridx);
			end
			S_SR_RD, S_SR_WAIT: begin
				ram_addr = AW'(scan_q);
			end
			S_TOP_RD, S_TOP_WAIT, S_EX_RDROOT, S_EX_WAITROOT: begin
				ram_addr = '0;
			end
			default: begin
			end
		endcase
	end

	assign in_ready  = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			cmd_q       <= '0;
			op_q        <= '0;
			cur_q       <= '0;
			pos_q       <= '0;
			other_q     <= '0;
			other_ent_q <= '0;
			lch_q       <= '0;
			sval_q      <= '0;
			scan_q      <= '0;
			status_q    <= '0;
			taken_q     <= '0;
			fpos_q      <= '0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						cmd_q    <= in_item.command;
						op_q     <= in_item.command;
						cur_q    <= {new_key, in_item.item_value};
						sval_q   <= in_item.item_value;
						status_q <= imhq_pkg::ST_OK;
						taken_q  <= '0;
						fpos_q   <= '0;
						scan_q   <= '0;
						case (imhq_pkg::cmd_t'(in_item.command))
							imhq_pkg::CMD_INSERT: begin
								if (count_q >= CW'(CAPACITY)) begin
									status_q <= imhq_pkg::ST_FULL;
									state_q  <= S_TOP_RD;
								end else begin
									pos_q   <= AW'(count_q);
									state_q <= S_INS_WR;
								end
							end
							imhq_pkg::CMD_EXTRACT: begin
								if (count_q == '0) begin
									status_q <= imhq_pkg::ST_EMPTY;
									state_q  <= S_TOP_RD;
								end else begin
									state_q <= S_EX_RDROOT;
								end
							end
							imhq_pkg::CMD_CHANGE: begin
								if (CW'(in_item.position) >= count_q ||
									32'(in_item.position) >= CAPACITY) begin
									status_q <= imhq_pkg::ST_RANGE;
									state_q  <= S_TOP_RD;
								end else begin
									pos_q   <= AW'(in_item.position);
									state_q <= S_CK_RD;
								end
							end
							default: begin
								status_q <= imhq_pkg::ST_NOT_FOUND;
								state_q  <= (count_q == '0) ? S_TOP_RD : S_SR_RD;
							end
						endcase
					end
				end
				S_INS_WR: begin
					count_q <= count_q + CW'(1);
					state_q <= S_UP_RDP;
				end
				// Sift up: cur_q sits at pos_q; compare with the parent.
				S_UP_RDP: begin
					if (pos_q == '0) begin
						fpos_q  <= pos_q;
						state_q <= S_TOP_RD;
					end else begin
						other_q <= (pos_q - AW'(1)) >> 1;
						state_q <= S_UP_WAITP;
					end
				end
				S_UP_WAITP: begin
					state_q <= S_UP_RDC;
				end
				S_UP_RDC: begin
					if (key_lt(cur_q, ram_rdata)) begin
						other_ent_q <= ram_rdata;
						state_q     <= S_UP_SWAP1;
					end else begin
						fpos_q  <= pos_q;
						state_q <= S_TOP_RD;
					end
				end
				S_UP_SWAP1: begin
					// Other entry is now in this slot; cur is written at the other slot via S_CK_WR.
					pos_q   <= other_q;
					state_q <= S_UP_WAITC;
				end
				S_UP_WAITC: begin
					// Write cur_q into its new slot via the change write path.
					state_q <= S_CK_WR;
				end
				S_EX_RDROOT: state_q <= S_EX_WAITROOT;
				S_EX_WAITROOT: begin
					state_q <= S_EX_RDLAST;
					count_q <= count_q - CW'(1);
				end
				S_EX_RDLAST: begin
					taken_q <= ram_rdata;
					state_q <= S_EX_WAITLAST;
				end
				S_EX_WAITLAST: begin
					cur_q   <= ram_rdata;
					pos_q   <= '0;
					state_q <= (count_q == '0) ? S_TOP_RD : S_EX_WRROOT;
				end
				S_EX_WRROOT: state_q <= S_DN_RDL;
				S_CK_RD: state_q <= S_CK_WAIT;
				S_CK_WAIT: begin
					cur_q[31:0] <= ram_rdata[31:0];
					// Direction: up if new key is strictly smaller.
					if (key_lt(cur_q, ram_rdata)) begin
						cmd_q <= imhq_pkg::CMD_INSERT;
					end else begin
						cmd_q <= imhq_pkg::CMD_CHANGE;
					end
					state_q <= S_CK_WR;
				end
				S_CK_WR: begin
					if (cmd_q == imhq_pkg::CMD_INSERT) begin
						state_q <= S_UP_RDP;
					end else begin
						state_q <= S_DN_RDL;
					end
				end
				// Sift down: read left then right child.
				S_DN_RDL: begin
					if (lidx >= (CW+1)'(count_q)) begin
						fpos_q  <= pos_q;
						state_q <= S_TOP_RD;
					end else begin
						state_q <= S_DN_WAITL;
					end
				end
				S_DN_WAITL: state_q <= S_DN_RDR;
				S_DN_RDR: begin
					lch_q       <= ram_rdata;
					other_ent_q <= ram_rdata;
					other_q     <= AW'(lidx);
					state_q     <= (ridx < (CW+1)'(count_q)) ? S_DN_WAITR : S_DN_SWAP1;
				end
				S_DN_WAITR: begin
					state_q <= S_DN_SWAP1;
				end
				S_DN_SWAP1: begin
					// When the right child wins, this state first chooses it and is
					// then entered again to compare it with the sifted entry.
					if (ridx < (CW+1)'(count_q) && other_q == AW'(lidx) &&
						ram_rdata != lch_q && key_lt(ram_rdata, lch_q)) begin
						other_ent_q <= ram_rdata;
						other_q     <= AW'(ridx);
						lch_q       <= ram_rdata;
						state_q     <= S_DN_SWAP1;
					end else if (key_lt(other_ent_q, cur_q)) begin
						cmd_q   <= imhq_pkg::CMD_CHANGE;
						state_q <= S_UP_SWAP1;
					end else begin
						fpos_q  <= pos_q;
						state_q <= S_TOP_RD;
					end
				end
				S_SR_RD: state_q <= S_SR_WAIT;
				S_SR_WAIT: begin
					if (ram_rdata[31:0] == sval_q) begin
						status_q <= imhq_pkg::ST_OK;
						fpos_q   <= AW'(scan_q);
						state_q  <= S_TOP_RD;
					end else if (scan_q + CW'(1) >= count_q) begin
						state_q <= S_TOP_RD;
					end else begin
						scan_q  <= scan_q + CW'(1);
						state_q <= S_SR_RD;
					end
				end
				S_TOP_RD: state_q <= S_TOP_WAIT;
				S_TOP_WAIT: begin
					out_q.status         <= status_q;
					out_q.taken_key      <= key_field(taken_q);
					out_q.taken_value    <= taken_q[31:0];
					// Only change-key and search report a position.
					out_q.found_position <= (op_q inside {imhq_pkg::CMD_CHANGE,
						imhq_pkg::CMD_SEARCH}) ? 6'(fpos_q) : '0;
					out_q.top_key        <= (count_q == '0) ? '0 : key_field(ram_rdata);
					out_q.top_value      <= (count_q == '0) ? '0 : ram_rdata[31:0];
					out_q.entry_count    <= 7'(count_q);
					out_valid_q          <= 1'b1;
					state_q              <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY)) else $error("entry count above capacity");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == S_IDLE) else $error("ready outside idle");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(out_q))
		else $error("result dropped");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> state_q != S_IDLE)
		else $error("count changed while idle");
`endif

endmodule
